FILE: rtl/owtr_pkg.sv
// Shared types and constants of the 1-Wire temperature reader.
`default_nettype none

package owtr_pkg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_RST_LOW = 5'd1,
        PH_RST_REL = 5'd2,
        PH_GAP     = 5'd3,
        PH_WR_LOW  = 5'd4,
        PH_WR_REL  = 5'd5,
        PH_CONV    = 5'd6,
        PH_RD_LOW  = 5'd7,
        PH_RD_REL  = 5'd8,
        PH_DONE    = 5'd9
    } t_phase;

    // Sequencer state apart from the tick counter.
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_idx;
        logic [7:0]  shift;
        logic [1:0]  step;
        logic [7:0]  low_hold;
        logic [7:0]  mag;
        logic [7:0]  high;
    } t_core;

    // Register indexes.
    localparam logic [2:0] REG_RUN_ENABLE    = 3'd0;
    localparam logic [2:0] REG_RESET_LOW     = 3'd1;
    localparam logic [2:0] REG_RESET_RELEASE = 3'd2;
    localparam logic [2:0] REG_GAP           = 3'd3;
    localparam logic [2:0] REG_SHORT         = 3'd4;
    localparam logic [2:0] REG_SLOT          = 3'd5;
    localparam logic [2:0] REG_CONV_WAIT     = 3'd6;

    // Register reset values.
    localparam logic        RST_RUN_ENABLE    = 1'b1;
    localparam logic [15:0] RST_RESET_LOW     = 16'd480;
    localparam logic [15:0] RST_RESET_RELEASE = 16'd480;
    localparam logic [15:0] RST_GAP           = 16'd100;
    localparam logic [7:0]  RST_SHORT         = 8'd6;
    localparam logic [7:0]  RST_SLOT          = 8'd64;
    localparam logic [23:0] RST_CONV_WAIT     = 24'd750000;

    // Widest raw timing register.
    localparam int RAW_W = 24;

    // Command bytes.
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;
    localparam logic [7:0] NEG_ONE_ADD    = 8'h01;

    // Command steps; during the read the step tells low byte from high byte.
    localparam logic [1:0] STEP_CONV_ROM  = 2'd0;
    localparam logic [1:0] STEP_CONV_CMD  = 2'd1;
    localparam logic [1:0] STEP_READ_ROM  = 2'd2;
    localparam logic [1:0] STEP_READ_CMD  = 2'd3;
    localparam logic [1:0] STEP_LOW_BYTE  = 2'd0;
    localparam logic [1:0] STEP_HIGH_BYTE = 2'd1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

FILE: rtl/one_wire_temperature_reader_unit.sv
// 1-Wire master top level: tick-driven DS18x20 style temperature reader.
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_line_level
//  out     | output    | o_out_valid/i_out_ready| o_drive_low, o_reading_valid,
//          |           |                        | o_temperature_magnitude, o_high_byte,
//          |           |                        | o_busy_res
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One tick word per cycle unless a stall or a skip holds it; each word gives one result
//  word through the input and then the result register. A timing part of zero length is
//  skipped on its own (at most ~100 per tick) while the word sits in the input register.
//  The input register and the result register part the two sides: a stalled result
//  does not stop one more tick word from being taken.
//  Synchronous active-low reset returns the sequencer to idle and the registers to
//  their defaults; there is no clearing pass.

module one_wire_temperature_reader_unit #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_line_level,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_drive_low,
    output logic             o_reading_valid,
    output logic [7:0]       o_temperature_magnitude,
    output logic [7:0]       o_high_byte,
    output logic             o_busy_res,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import owtr_pkg::*;

    localparam int LEN_W  = COUNT_WIDTH + 1;
    localparam int WIDE_W = (LEN_W > RAW_W) ? LEN_W : RAW_W;
    localparam logic [WIDE_W-1:0] LEN_CAP = WIDE_W'(1) << COUNT_WIDTH;

    // Configuration registers.
    logic        r_run_en;
    logic [15:0] r_rst_low;
    logic [15:0] r_rst_rel;
    logic [15:0] r_gap;
    logic [7:0]  r_short;
    logic [7:0]  r_slot;
    logic [23:0] r_conv;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // Sequencer.
    t_core                  r_core;
    logic [COUNT_WIDTH-1:0] r_tick;

    // Input and result registers.
    logic r_in_valid;
    logic r_in_lvl;
    logic r_out_valid;
    logic r_drive;
    logic r_rdg_valid;
    logic [7:0] r_mag;
    logic [7:0] r_high;
    logic r_busy;

    t_core                  s0;
    t_core                  s_skip;
    t_core                  n_core;
    logic [COUNT_WIDTH-1:0] tick0;
    logic [COUNT_WIDTH-1:0] n_tick;
    logic [RAW_W-1:0]       raw_len;
    logic [WIDE_W-1:0]      wide_len;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       tick_inc;
    logic                   skip;
    logic                   fire;
    logic                   out_free;
    logic                   accept;
    logic                   drive;
    logic                   rdg_valid;
    logic                   busy;

    function automatic t_core end_part(input t_core s);
        t_core r;
        r = s;
        unique case (s.phase)
            PH_RST_LOW: r.phase = PH_RST_REL;
            PH_RST_REL: r.phase = PH_GAP;
            PH_GAP: begin
                r.shift   = CMD_SKIP_ROM;
                r.bit_idx = '0;
                r.phase   = PH_WR_LOW;
            end
            PH_WR_LOW: r.phase = PH_WR_REL;
            PH_WR_REL: begin
                r.shift   = {1'b0, s.shift[7:1]};
                r.bit_idx = s.bit_idx + 4'd1;
                r.phase   = PH_WR_LOW;
                if (r.bit_idx >= BITS_PER_BYTE) begin
                    r.bit_idx = '0;
                    case (s.step)
                        STEP_CONV_ROM: begin
                            r.step  = STEP_CONV_CMD;
                            r.shift = CMD_CONVERT;
                        end
                        STEP_CONV_CMD: r.phase = PH_CONV;
                        STEP_READ_ROM: begin
                            r.step  = STEP_READ_CMD;
                            r.shift = CMD_READ_SCRPD;
                        end
                        default: begin
                            r.step  = STEP_LOW_BYTE;
                            r.shift = '0;
                            r.phase = PH_RD_LOW;
                        end
                    endcase
                end
            end
            PH_CONV: begin
                r.step  = STEP_READ_ROM;
                r.phase = PH_RST_LOW;
            end
            PH_RD_LOW: r.phase = PH_RD_REL;
            PH_RD_REL: begin
                r.bit_idx = s.bit_idx + 4'd1;
                r.phase   = PH_RD_LOW;
                if (r.bit_idx >= BITS_PER_BYTE) begin
                    r.bit_idx = '0;
                    if (s.step == STEP_LOW_BYTE) begin
                        r.low_hold = s.shift;
                        r.shift    = '0;
                        r.step     = STEP_HIGH_BYTE;
                    end else begin
                        r.high  = s.shift;
                        r.mag   = (s.shift != 8'd0) ? (~s.low_hold) + NEG_ONE_ADD
                                                    : s.low_hold;
                        r.step  = STEP_LOW_BYTE;
                        r.phase = PH_DONE;
                    end
                end
            end
            default: r.phase = PH_IDLE;
        endcase
        return r;
    endfunction

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_en  <= RST_RUN_ENABLE;
            r_rst_low <= RST_RESET_LOW;
            r_rst_rel <= RST_RESET_RELEASE;
            r_gap     <= RST_GAP;
            r_short   <= RST_SHORT;
            r_slot    <= RST_SLOT;
            r_conv    <= RST_CONV_WAIT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RUN_ENABLE:    r_run_en  <= pwdata[0];
                REG_RESET_LOW:     r_rst_low <= pwdata[15:0];
                REG_RESET_RELEASE: r_rst_rel <= pwdata[15:0];
                REG_GAP:           r_gap     <= pwdata[15:0];
                REG_SHORT:         r_short   <= pwdata[7:0];
                REG_SLOT:          r_slot    <= pwdata[7:0];
                REG_CONV_WAIT:     r_conv    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RUN_ENABLE:    prdata = {31'd0, r_run_en};
            REG_RESET_LOW:     prdata = {16'd0, r_rst_low};
            REG_RESET_RELEASE: prdata = {16'd0, r_rst_rel};
            REG_GAP:           prdata = {16'd0, r_gap};
            REG_SHORT:         prdata = {24'd0, r_short};
            REG_SLOT:          prdata = {24'd0, r_slot};
            REG_CONV_WAIT:     prdata = {8'd0, r_conv};
            default:           prdata = '0;
        endcase
    end

    // Start a round from idle, then find the length of the current part.
    always_comb begin
        s0    = r_core;
        tick0 = r_tick;
        if (r_core.phase == PH_IDLE && r_run_en) begin
            s0.phase   = PH_RST_LOW;
            s0.bit_idx = '0;
            s0.step    = STEP_CONV_ROM;
            tick0      = '0;
        end
        case (s0.phase)
            PH_RST_LOW: raw_len = RAW_W'(r_rst_low);
            PH_RST_REL: raw_len = RAW_W'(r_rst_rel);
            PH_GAP:     raw_len = RAW_W'(r_gap);
            PH_WR_LOW:  raw_len = s0.shift[0] ? RAW_W'(r_short) : RAW_W'(r_slot);
            PH_WR_REL:  raw_len = s0.shift[0] ? RAW_W'(r_slot) : RAW_W'(r_short);
            PH_CONV:    raw_len = r_conv;
            PH_RD_LOW:  raw_len = RAW_W'(r_short);
            PH_RD_REL:  raw_len = RAW_W'(r_slot);
            default:    raw_len = RAW_W'(1);
        endcase
        wide_len = WIDE_W'(raw_len);
        if (wide_len > LEN_CAP) begin
            wide_len = LEN_CAP;
        end
        len = wide_len[LEN_W-1:0];
    end

    // Next state: either drop one zero-length part, or run the tick proper.
    always_comb begin
        skip = r_in_valid && (s0.phase != PH_IDLE) && (len == '0);

        s_skip = s0;
        if (s0.phase == PH_RD_REL) begin
            s_skip.shift = {r_in_lvl, s0.shift[7:1]};
        end
        s_skip = end_part(s_skip);

        n_core   = s0;
        n_tick   = tick0;
        tick_inc = LEN_W'(tick0) + LEN_W'(1);
        if (s0.phase == PH_RD_REL && tick0 == '0) begin
            n_core.shift = {r_in_lvl, s0.shift[7:1]};
        end
        if (s0.phase != PH_IDLE) begin
            if (tick_inc >= len) begin
                n_core = end_part(n_core);
                n_tick = '0;
            end else begin
                n_tick = tick_inc[COUNT_WIDTH-1:0];
            end
        end
    end

    // Bus outputs follow the phase the tick runs in.
    always_comb begin
        drive     = (s0.phase == PH_RST_LOW) || (s0.phase == PH_WR_LOW) ||
                    (s0.phase == PH_RD_LOW);
        rdg_valid = (s0.phase == PH_DONE);
        busy      = (s0.phase != PH_IDLE) && (s0.phase != PH_DONE);
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && !skip && out_free;
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core      <= '{phase: PH_IDLE, default: '0};
            r_tick      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (skip) begin
                r_core <= s_skip;
                r_tick <= '0;
            end else if (fire) begin
                r_core <= n_core;
                r_tick <= n_tick;
            end

            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_lvl <= i_line_level;
        end
        if (fire) begin
            r_drive     <= drive;
            r_rdg_valid <= rdg_valid;
            r_busy      <= busy;
            r_mag       <= n_core.mag;
            r_high      <= n_core.high;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_drive_low             = r_drive;
    assign o_reading_valid         = r_rdg_valid;
    assign o_temperature_magnitude = r_mag;
    assign o_high_byte             = r_high;
    assign o_busy_res              = r_busy;

endmodule

`default_nettype wire

FILE: rtl/owtr_checker.sv
// Port-level checker of the temperature reader and its bind.
`default_nettype none

module owtr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_drive_low,
    input wire logic        o_reading_valid,
    input wire logic [7:0]  o_temperature_magnitude,
    input wire logic [7:0]  o_high_byte,
    input wire logic        o_busy_res
);

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && !i_out_ready) |=>
            ($stable(o_drive_low) && $stable(o_reading_valid) &&
             $stable(o_temperature_magnitude) && $stable(o_high_byte) &&
             $stable(o_busy_res)))
        else $error("stalled result word changed");

    // The reading tick drives nothing and is outside the round.
    a_reading_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_valid) |-> (!o_drive_low && !o_busy_res))
        else $error("reading word shows bus activity");

    // The bus is pulled low only within a round.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_low) |-> o_busy_res)
        else $error("bus driven outside a round");

endmodule

bind one_wire_temperature_reader_unit owtr_checker u_owtr_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_out_valid             (o_out_valid),
    .i_out_ready             (i_out_ready),
    .o_drive_low             (o_drive_low),
    .o_reading_valid         (o_reading_valid),
    .o_temperature_magnitude (o_temperature_magnitude),
    .o_high_byte             (o_high_byte),
    .o_busy_res              (o_busy_res)
);

`default_nettype wire
